/* hdl/vbfp_pkg.sv */
// Shared constants, command codes and types of the variable bit field packer.
// No dependencies; used by vbfp_merge and variable_bit_field_packer_core.
package vbfp_pkg;

  localparam int MAX_WORD_BITS = 32;
  localparam int WORD_CAP = (MAX_WORD_BITS < 32) ? MAX_WORD_BITS : 32;
  localparam logic [5:0] WORD_CAP_BITS = 6'(WORD_CAP);
  localparam logic [5:0] RESET_WORD_BITS = 6'd32;

  localparam logic CMD_PACK  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic        emit;
    logic [31:0] word;
    logic [31:0] partial_next;
    logic [5:0]  fill_next;
  } merge_out_t;

  function automatic logic [63:0] low_mask(input logic [6:0] n);
    low_mask = (64'd1 << n) - 64'd1;
  endfunction

endpackage

/* hdl/vbfp_merge.sv */
// Combinational merge of one pack or flush transaction into the partial word.
// Depends on vbfp_pkg for the command codes, masks and the merge_out_t result.
module vbfp_merge (
  input  logic                 command,
  input  logic [31:0]          field_value,
  input  logic [5:0]           field_bits,
  input  logic [5:0]           word_bits,
  input  logic [31:0]          partial,
  input  logic [5:0]           fill,
  output vbfp_pkg::merge_out_t result
);

  logic [5:0]  width;
  logic [5:0]  nbits;
  logic [63:0] wmask;
  logic [63:0] fill_mask;
  logic [63:0] bits_mask;
  logic [63:0] acc;
  logic [63:0] rest;
  logic [6:0]  total;
  logic [6:0]  remain;
  logic [63:0] remain_mask;

  always_comb begin
    if (word_bits == 6'd0) begin
      width = 6'd1;
    end else if (word_bits > vbfp_pkg::WORD_CAP_BITS) begin
      width = vbfp_pkg::WORD_CAP_BITS;
    end else begin
      width = word_bits;
    end
    nbits = (field_bits > width) ? width : field_bits;
  end

  assign wmask       = vbfp_pkg::low_mask({1'b0, width});
  assign fill_mask   = vbfp_pkg::low_mask({1'b0, fill});
  assign bits_mask   = vbfp_pkg::low_mask({1'b0, nbits});
  assign acc         = ({32'd0, partial} & fill_mask)
                     | (({32'd0, field_value} & bits_mask) << fill);
  assign total       = {1'b0, fill} + {1'b0, nbits};
  assign remain      = total - {1'b0, width};
  assign rest        = acc >> width;
  assign remain_mask = vbfp_pkg::low_mask(remain);

  always_comb begin
    result.emit         = 1'b0;
    result.word         = 32'd0;
    result.partial_next = partial;
    result.fill_next    = fill;
    if (command == vbfp_pkg::CMD_FLUSH) begin
      if (fill != 6'd0) begin
        result.emit         = 1'b1;
        result.word         = partial & wmask[31:0];
        result.partial_next = 32'd0;
        result.fill_next    = 6'd0;
      end
    end else if (nbits != 6'd0) begin
      if (total < {1'b0, width}) begin
        result.partial_next = acc[31:0];
        result.fill_next    = total[5:0];
      end else begin
        result.emit         = 1'b1;
        result.word         = acc[31:0] & wmask[31:0];
        result.partial_next = rest[31:0] & remain_mask[31:0];
        result.fill_next    = remain[5:0];
      end
    end
  end

endmodule

/* hdl/variable_bit_field_packer_core.sv */
// Variable bit field packer, LSB first: input register, merge logic, result register.
// An input transaction passes the input register, the merge logic and the result register to packed_word;
// throughput 1 transaction per cycle while out_stall does not hold the pipeline, set by the single merge pass.
// Depends on vbfp_pkg and vbfp_merge.
// Reset (rst, synchronous, active high): word_bits returns to 32, partial word and fill
// clear, both pipeline registers empty.
module variable_bit_field_packer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] field_value,
  input  logic [5:0]  field_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] packed_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  logic        item_valid;
  logic        item_command;
  logic [31:0] item_value;
  logic [5:0]  item_bits;
  logic [5:0]  word_bits;
  logic [31:0] partial;
  logic [5:0]  fill;
  logic        advance;
  logic        accept;
  vbfp_pkg::merge_out_t merged;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = item_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  vbfp_merge u_merge (
    .command     (item_command),
    .field_value (item_value),
    .field_bits  (item_bits),
    .word_bits   (word_bits),
    .partial     (partial),
    .fill        (fill),
    .result      (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_command <= command;
      item_value   <= field_value;
      item_bits    <= field_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_bits <= vbfp_pkg::RESET_WORD_BITS;
      partial   <= 32'd0;
      fill      <= 6'd0;
    end else if (cfg_valid && cfg_ready) begin
      word_bits <= cfg_data;
      partial   <= 32'd0;
      fill      <= 6'd0;
    end else if (item_valid && advance) begin
      partial   <= merged.partial_next;
      fill      <= merged.fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && merged.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && merged.emit) begin
      packed_word <= merged.word;
    end
  end

endmodule

/* tb/sv/tb_variable_bit_field_packer_core.sv */
// Testbench for variable_bit_field_packer_core: directed and random pack/flush traffic
// with random idling on both sides, checked against a predictor of the packing state.
// Depends on vbfp_pkg and the packer RTL.
module tb_variable_bit_field_packer_core;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int MAX_REPORTS = 10;
  localparam longint TIMEOUT = 64'd12_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = vbfp_pkg::CMD_PACK;
  logic [31:0] field_value = '0;
  logic [5:0]  field_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] packed_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  logic [31:0] expected_words[$];
  logic [5:0]  pred_word_bits = vbfp_pkg::RESET_WORD_BITS;
  logic [31:0] pred_partial = '0;
  int unsigned pred_fill = 0;
  int unsigned mismatches = 0;
  bit          idle_enable = 1'b1;
  bit          stall_enable = 1'b1;
  bit          hold_off_req = 1'b0;

  variable_bit_field_packer_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .field_value(field_value),
    .field_bits (field_bits),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .packed_word(packed_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #(TIMEOUT);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] bit_mask(input int unsigned n);
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int unsigned active_width();
    int unsigned w;
    w = pred_word_bits;
    if (w == 0) w = 1;
    if (w > vbfp_pkg::WORD_CAP) w = vbfp_pkg::WORD_CAP;
    return w;
  endfunction

  function automatic void queue_word(input logic [31:0] w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void predict_packed_word(input logic cmd, input logic [31:0] val,
                                              input logic [5:0] nb);
    int unsigned width;
    int unsigned n;
    int unsigned total;
    logic [63:0] wmask;
    logic [63:0] acc;
    width = active_width();
    wmask = bit_mask(width);
    if (cmd == vbfp_pkg::CMD_FLUSH) begin
      if (pred_fill != 0) begin
        queue_word(pred_partial & wmask[31:0]);
        pred_partial = '0;
        pred_fill = 0;
      end
      return;
    end
    n = nb;
    if (n == 0) return;
    if (n > width) n = width;
    acc = ({32'd0, pred_partial} & bit_mask(pred_fill))
        | (({32'd0, val} & bit_mask(n)) << pred_fill);
    total = pred_fill + n;
    if (total < width) begin
      pred_partial = acc[31:0];
      pred_fill = total;
    end else begin
      queue_word(acc[31:0] & wmask[31:0]);
      pred_fill = total - width;
      pred_partial = 32'((acc >> width) & bit_mask(pred_fill));
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void report_mismatch(input logic [31:0] exp_word, input logic [31:0] act,
                                          input bit unexpected);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (unexpected) $display("packed_word 0x%08h arrived with nothing expected", act);
      else $display("packed_word mismatch: expected 0x%08h, got 0x%08h", exp_word, act);
    end
  endfunction

  always @(posedge clk) begin : word_checker
    logic [31:0] exp_word;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch('0, packed_word, 1'b1);
      end else begin
        exp_word = expected_words.pop_front();
        if (packed_word !== exp_word) report_mismatch(exp_word, packed_word, 1'b0);
      end
    end
  end

  initial begin : out_stall_gen
    int unsigned n;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!stall_enable) begin
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [31:0] val, input logic [5:0] nb);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    field_value <= val;
    field_bits <= nb;
    do @(posedge clk); while (in_stall);
    predict_packed_word(cmd, val, nb);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_word_bits(input logic [5:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_word_bits = v;
    pred_partial = '0;
    pred_fill = 0;
  endtask

  task automatic test_default_width();
    send_item(vbfp_pkg::CMD_PACK, 32'hFFFF_FFFF, 6'd32);
    send_item(vbfp_pkg::CMD_PACK, 32'h0000_0000, 6'd32);
    send_item(vbfp_pkg::CMD_PACK, 32'hFFFF_FFFF, 6'd0);
    send_item(vbfp_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 6'd63);
    send_item(vbfp_pkg::CMD_PACK, 32'h0000_001F, 6'd5);
    send_item(vbfp_pkg::CMD_PACK, 32'hA5A5_A5A5, 6'd63);
    send_item(vbfp_pkg::CMD_FLUSH, 32'h1234_5678, 6'd32);
    send_item(vbfp_pkg::CMD_PACK, 32'h0000_0001, 6'd1);
    send_item(vbfp_pkg::CMD_FLUSH, 32'h0000_0000, 6'd0);
  endtask

  task automatic test_width_extremes();
    write_word_bits(6'd0);
    send_item(vbfp_pkg::CMD_PACK, 32'h0000_0001, 6'd1);
    send_item(vbfp_pkg::CMD_PACK, 32'hFFFF_FFFE, 6'd3);
    send_item(vbfp_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 6'd1);
    write_word_bits(6'd63);
    send_item(vbfp_pkg::CMD_PACK, 32'h000F_ABCD, 6'd20);
    send_item(vbfp_pkg::CMD_PACK, 32'h0005_4321, 6'd20);
    send_item(vbfp_pkg::CMD_FLUSH, 32'h0, 6'd0);
  endtask

  task automatic test_midstream_width_write();
    write_word_bits(6'd7);
    send_item(vbfp_pkg::CMD_PACK, 32'h0000_0015, 6'd5);
    send_item(vbfp_pkg::CMD_PACK, 32'h0000_001A, 6'd5);
    send_item(vbfp_pkg::CMD_FLUSH, 32'h0, 6'd0);
    send_item(vbfp_pkg::CMD_PACK, 32'h0000_0005, 6'd3);
    write_word_bits(6'd12);
    send_item(vbfp_pkg::CMD_FLUSH, 32'h0, 6'd0);
  endtask

  task automatic test_output_backpressure();
    int i;
    write_word_bits(6'd8);
    idle_enable = 1'b0;
    hold_off_req = 1'b1;
    for (i = 0; i < 64; i++) send_item(vbfp_pkg::CMD_PACK, $urandom, 6'd8);
    idle_enable = 1'b1;
    settle();
  endtask

  task automatic test_random_stream(input int unsigned n_items);
    logic [5:0] widths[10] = '{6'd32, 6'd1, 6'd8, 6'd0, 6'd17, 6'd63, 6'd31, 6'd33, 6'd5, 6'd24};
    int phase;
    int i;
    int unsigned r;
    int unsigned per_phase;
    per_phase = n_items / 12;
    for (phase = 0; phase < 12; phase++) begin
      if (phase < 10) write_word_bits(widths[phase]);
      else write_word_bits(6'($urandom_range(0, 63)));
      idle_enable = (phase % 3) != 2;
      stall_enable = (phase % 4) != 3;
      for (i = 0; i < per_phase; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) send_item(vbfp_pkg::CMD_FLUSH, $urandom, 6'($urandom_range(0, 63)));
        else if (r < 12) send_item(vbfp_pkg::CMD_PACK, $urandom, 6'd0);
        else if (r < 18) send_item(vbfp_pkg::CMD_PACK, $urandom, 6'($urandom_range(0, 63)));
        else send_item(vbfp_pkg::CMD_PACK, $urandom, 6'($urandom_range(1, active_width())));
      end
    end
    idle_enable = 1'b1;
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_width();
    test_width_extremes();
    test_midstream_width_write();
    test_output_backpressure();
    test_random_stream(1000);
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
